FILE: rtl/tpi_pkg.sv
// Shared types, constants and lookup functions for the turtle path interpreter.
package tpi_pkg;

	localparam int SYM_W     = 8;
	localparam int COORD_W   = 32;
	localparam int ANG_W     = 16;
	localparam int STEP_W    = 31;
	localparam int MAG_W     = 17;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int SLOT_MAX  = 8;

	localparam int FOLD_W = 15;
	localparam int FRAC_W = 9;
	localparam int IDX_W  = 6;

	localparam int PROD_W  = STEP_W + MAG_W;
	localparam int DELTA_W = PROD_W - 16;

	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_PTR_W = 2;
	localparam int OFIFO_CNT_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DRAW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PUSH_POP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_POS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_HDG = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TURN      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd7;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_FULL  = 2'd1;
	localparam logic [1:0] ERR_EMPTY = 2'd2;

	localparam logic [ANG_W-1:0]  QUARTER_TURN = 16'h4000;
	localparam logic [FOLD_W-1:0] QUARTER_SPAN = 15'd16384;
	localparam logic [MAG_W+FRAC_W-1:0] INTERP_HALF = 26'd256;
	localparam logic [PROD_W-1:0] ROUND_HALF = 48'd32768;

	typedef logic [SYM_W-1:0]          sym_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [ANG_W-1:0]          angle_t;
	typedef logic [MAG_W-1:0]          mag_t;

	typedef struct packed {
		logic       draw;
		logic       restart;
		logic       push_wr;
		logic       pop_rd;
		logic [1:0] err;
	} pose_ctrl_t;

	typedef struct packed {
		coord_t     from_x;
		coord_t     from_y;
		coord_t     to_x;
		coord_t     to_y;
		logic       seg_valid;
		logic [1:0] err;
	} seg_t;

	function automatic mag_t qsine(input logic [IDX_W-1:0] k);
		mag_t v;
		unique case (k)
			6'd0:  v = 17'd0;
			6'd1:  v = 17'd3216;
			6'd2:  v = 17'd6424;
			6'd3:  v = 17'd9616;
			6'd4:  v = 17'd12785;
			6'd5:  v = 17'd15924;
			6'd6:  v = 17'd19024;
			6'd7:  v = 17'd22078;
			6'd8:  v = 17'd25080;
			6'd9:  v = 17'd28020;
			6'd10: v = 17'd30893;
			6'd11: v = 17'd33692;
			6'd12: v = 17'd36410;
			6'd13: v = 17'd39040;
			6'd14: v = 17'd41576;
			6'd15: v = 17'd44011;
			6'd16: v = 17'd46341;
			6'd17: v = 17'd48559;
			6'd18: v = 17'd50660;
			6'd19: v = 17'd52639;
			6'd20: v = 17'd54491;
			6'd21: v = 17'd56212;
			6'd22: v = 17'd57798;
			6'd23: v = 17'd59244;
			6'd24: v = 17'd60547;
			6'd25: v = 17'd61705;
			6'd26: v = 17'd62714;
			6'd27: v = 17'd63572;
			6'd28: v = 17'd64277;
			6'd29: v = 17'd64827;
			6'd30: v = 17'd65220;
			6'd31: v = 17'd65457;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

	function automatic logic in_set(input logic [CFG_W-1:0] r, input sym_t s, input int slots);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < SLOT_MAX; k++) begin
			if (k < slots && r[8*k +: 8] != 8'd0 && r[8*k +: 8] == s) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

FILE: rtl/tpi_trig.sv
// Two-stage sine and cosine lookup with linear interpolation from the quarter-wave table.
module tpi_trig (
	input  logic            clk,
	input  tpi_pkg::angle_t hdg,
	output tpi_pkg::mag_t   cos_mag_s3,
	output logic            cos_neg_s3,
	output tpi_pkg::mag_t   sin_mag_s3,
	output logic            sin_neg_s3
);
	import tpi_pkg::*;

	angle_t ang [2];
	mag_t   mag_s3 [2];
	logic   neg_s3 [2];

	assign ang[0] = hdg + QUARTER_TURN;
	assign ang[1] = hdg;

	for (genvar i = 0; i < 2; i++) begin : g_lane
		logic [1:0]              quad;
		logic [FOLD_W-1:0]       qq;
		logic [IDX_W-1:0]        idx;
		mag_t                    a;
		mag_t                    b;
		mag_t                    a_s2;
		mag_t                    d_s2;
		logic [FRAC_W-1:0]       f_s2;
		logic                    neg_s2;
		logic [MAG_W+FRAC_W-1:0] prod;

		assign quad = ang[i][ANG_W-1 -: 2];
		assign qq   = quad[0] ? (QUARTER_SPAN - {1'b0, ang[i][FOLD_W-2:0]})
		                      : {1'b0, ang[i][FOLD_W-2:0]};
		assign idx  = qq[FOLD_W-1:FRAC_W];
		assign a    = qsine(idx);
		assign b    = qsine(idx + 6'd1);
		assign prod = (MAG_W+FRAC_W)'(d_s2) * (MAG_W+FRAC_W)'(f_s2);

		always_ff @(posedge clk) begin
			a_s2      <= a;
			d_s2      <= b - a;
			f_s2      <= qq[FRAC_W-1:0];
			neg_s2    <= quad[1];
			mag_s3[i] <= a_s2 + MAG_W'((prod + INTERP_HALF) >> FRAC_W);
			neg_s3[i] <= neg_s2;
		end
	end

	assign cos_mag_s3 = mag_s3[0];
	assign cos_neg_s3 = neg_s3[0];
	assign sin_mag_s3 = mag_s3[1];
	assign sin_neg_s3 = neg_s3[1];

endmodule

FILE: rtl/tpi_ctrl.sv
// Symbol decode, stack count and heading stack memory with heading read-modify-write.
module tpi_ctrl #(
	parameter int STACK_DEPTH  = 256,
	parameter int SYMBOL_SLOTS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_fire,
	input  tpi_pkg::sym_t                  symbol,
	input  logic                           restart,
	input  logic [tpi_pkg::CFG_W-1:0]      draw_syms,
	input  logic [tpi_pkg::CFG_W-1:0]      left_syms,
	input  logic [tpi_pkg::CFG_W-1:0]      right_syms,
	input  logic [2*tpi_pkg::SYM_W-1:0]    push_pop,
	input  tpi_pkg::angle_t                start_heading,
	input  tpi_pkg::angle_t                turn_angle,
	output logic                           busy_s1,
	output tpi_pkg::angle_t                hdg_in,
	output logic                           v_s3,
	output tpi_pkg::pose_ctrl_t            ctrl_s3,
	output logic [$clog2(STACK_DEPTH)-1:0] addr_s3
);
	import tpi_pkg::*;

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

	logic              v_s1;
	sym_t              sym_s1;
	logic              restart_s1;
	logic              v_s2;
	pose_ctrl_t        ctrl_s2;
	logic [ADDR_W-1:0] addr_s2;
	angle_t            hd_turn_s2;
	logic [CNT_W-1:0]  cnt_q;
	angle_t            heading_q;
	angle_t            hd_rd_q;
	angle_t            hd_mem [STACK_DEPTH];

	logic              is_draw;
	logic              is_left;
	logic              is_right;
	logic              is_push;
	logic              is_pop;
	logic              push_ok;
	logic              pop_ok;
	logic [1:0]        err;
	logic [CNT_W-1:0]  cnt_in;
	logic [CNT_W-1:0]  cnt_mid;
	logic [CNT_W-1:0]  cnt_dec;
	logic [CNT_W-1:0]  cnt_out;
	angle_t            hd_turn;
	pose_ctrl_t        pc;
	logic [ADDR_W-1:0] addr;

	assign busy_s1  = v_s1;
	assign cnt_in   = restart_s1 ? '0 : cnt_q;
	assign hdg_in   = restart_s1 ? start_heading : heading_q;
	assign is_draw  = in_set(draw_syms, sym_s1, SYMBOL_SLOTS);
	assign is_left  = in_set(left_syms, sym_s1, SYMBOL_SLOTS);
	assign is_right = in_set(right_syms, sym_s1, SYMBOL_SLOTS);
	assign is_push  = push_pop[SYM_W-1:0] != '0 && push_pop[SYM_W-1:0] == sym_s1;
	assign is_pop   = push_pop[2*SYM_W-1:SYM_W] != '0 && push_pop[2*SYM_W-1:SYM_W] == sym_s1;
	assign hd_turn  = hdg_in + (is_left ? turn_angle : '0) - (is_right ? turn_angle : '0);

	always_comb begin
		err     = ERR_NONE;
		push_ok = 1'b0;
		if (is_push) begin
			if (cnt_in == CNT_FULL) begin
				err = ERR_FULL;
			end else begin
				push_ok = 1'b1;
			end
		end
		cnt_mid = cnt_in + CNT_W'(push_ok);
		pop_ok  = 1'b0;
		if (is_pop) begin
			if (cnt_mid == '0) begin
				err = ERR_EMPTY;
			end else begin
				pop_ok = 1'b1;
			end
		end
		cnt_out    = cnt_mid - CNT_W'(pop_ok);
		cnt_dec    = cnt_in - CNT_W'(1);
		pc.draw    = is_draw;
		pc.restart = restart_s1;
		pc.push_wr = push_ok && !pop_ok;
		pc.pop_rd  = pop_ok && !push_ok;
		pc.err     = err;
		addr       = pc.pop_rd ? cnt_dec[ADDR_W-1:0] : cnt_in[ADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (v_s1 && pc.push_wr) begin
			hd_mem[addr] <= hd_turn;
		end
		if (v_s1 && pc.pop_rd) begin
			hd_rd_q <= hd_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			cnt_q     <= '0;
			heading_q <= '0;
		end else begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s1) begin
				cnt_q <= cnt_out;
			end
			if (v_s2) begin
				heading_q <= ctrl_s2.pop_rd ? hd_rd_q : hd_turn_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sym_s1     <= symbol;
			restart_s1 <= restart;
		end
		ctrl_s2    <= pc;
		addr_s2    <= addr;
		hd_turn_s2 <= hd_turn;
		ctrl_s3    <= ctrl_s2;
		addr_s3    <= addr_s2;
	end

endmodule

FILE: rtl/tpi_pose.sv
// Step multiply, rounding, saturating move and position stack memory.
module tpi_pose #(
	parameter int STACK_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           v_s3,
	input  tpi_pkg::pose_ctrl_t            ctrl_s3,
	input  logic [$clog2(STACK_DEPTH)-1:0] addr_s3,
	input  tpi_pkg::mag_t                  cos_mag_s3,
	input  logic                           cos_neg_s3,
	input  tpi_pkg::mag_t                  sin_mag_s3,
	input  logic                           sin_neg_s3,
	input  logic [tpi_pkg::STEP_W-1:0]     step_length,
	input  logic [tpi_pkg::CFG_W-1:0]      start_position,
	output logic                           done,
	output logic                           res_vld,
	output tpi_pkg::seg_t                  res
);
	import tpi_pkg::*;

	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam logic signed [COORD_W+1:0] SAT_MAX = 34'sd2147483647;
	localparam logic signed [COORD_W+1:0] SAT_MIN = -34'sd2147483648;

	function automatic coord_t move_sat(input coord_t p, input logic [DELTA_W-1:0] d,
	                                    input logic neg);
		logic signed [COORD_W+1:0] ps;
		logic signed [COORD_W+1:0] ds;
		logic signed [COORD_W+1:0] r;
		ps = {{2{p[COORD_W-1]}}, p};
		ds = {2'b00, d};
		r  = neg ? ps - ds : ps + ds;
		if (r > SAT_MAX) begin
			r = SAT_MAX;
		end else if (r < SAT_MIN) begin
			r = SAT_MIN;
		end
		return r[COORD_W-1:0];
	endfunction

	logic                v_s4;
	logic                v_s5;
	pose_ctrl_t          ctrl_s4;
	pose_ctrl_t          ctrl_s5;
	logic [ADDR_W-1:0]   addr_s4;
	logic [ADDR_W-1:0]   addr_s5;
	logic [PROD_W-1:0]   prod_x_s4;
	logic [PROD_W-1:0]   prod_y_s4;
	logic                neg_x_s4;
	logic                neg_y_s4;
	logic [DELTA_W-1:0]  dx_s5;
	logic [DELTA_W-1:0]  dy_s5;
	logic                neg_x_s5;
	logic                neg_y_s5;
	coord_t              pos_x_q;
	coord_t              pos_y_q;
	logic [2*COORD_W-1:0] xy_rd_q;
	logic [2*COORD_W-1:0] xy_mem [STACK_DEPTH];

	coord_t pin_x;
	coord_t pin_y;
	coord_t sat_x;
	coord_t sat_y;
	coord_t new_x;
	coord_t new_y;

	assign pin_x = ctrl_s5.restart ? start_position[COORD_W-1:0] : pos_x_q;
	assign pin_y = ctrl_s5.restart ? start_position[2*COORD_W-1:COORD_W] : pos_y_q;
	assign sat_x = move_sat(pin_x, dx_s5, neg_x_s5);
	assign sat_y = move_sat(pin_y, dy_s5, neg_y_s5);
	assign new_x = ctrl_s5.draw ? sat_x : pin_x;
	assign new_y = ctrl_s5.draw ? sat_y : pin_y;

	assign done          = v_s5;
	assign res_vld       = v_s5 && (ctrl_s5.draw || ctrl_s5.err != ERR_NONE);
	assign res.from_x    = ctrl_s5.draw ? pin_x : '0;
	assign res.from_y    = ctrl_s5.draw ? pin_y : '0;
	assign res.to_x      = ctrl_s5.draw ? sat_x : '0;
	assign res.to_y      = ctrl_s5.draw ? sat_y : '0;
	assign res.seg_valid = ctrl_s5.draw;
	assign res.err       = ctrl_s5.err;

	always_ff @(posedge clk) begin
		if (v_s5 && ctrl_s5.push_wr) begin
			xy_mem[addr_s5] <= {new_y, new_x};
		end
		if (v_s4 && ctrl_s4.pop_rd) begin
			xy_rd_q <= xy_mem[addr_s4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			pos_x_q <= '0;
			pos_y_q <= '0;
		end else begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (v_s5) begin
				pos_x_q <= ctrl_s5.pop_rd ? xy_rd_q[COORD_W-1:0] : new_x;
				pos_y_q <= ctrl_s5.pop_rd ? xy_rd_q[2*COORD_W-1:COORD_W] : new_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_x_s4 <= PROD_W'(step_length) * PROD_W'(cos_mag_s3);
		prod_y_s4 <= PROD_W'(step_length) * PROD_W'(sin_mag_s3);
		neg_x_s4  <= cos_neg_s3;
		neg_y_s4  <= sin_neg_s3;
		ctrl_s4   <= ctrl_s3;
		addr_s4   <= addr_s3;
		dx_s5     <= DELTA_W'((prod_x_s4 + ROUND_HALF) >> 16);
		dy_s5     <= DELTA_W'((prod_y_s4 + ROUND_HALF) >> 16);
		neg_x_s5  <= neg_x_s4;
		neg_y_s5  <= neg_y_s4;
		ctrl_s5   <= ctrl_s4;
		addr_s5   <= addr_s4;
	end

endmodule

FILE: rtl/tpi_fifo.sv
// Result queue between the pipeline and the output channel.
module tpi_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  tpi_pkg::seg_t                   wr_data,
	input  logic                            rd_en,
	output logic                            rd_valid,
	output tpi_pkg::seg_t                   rd_data,
	output logic [tpi_pkg::OFIFO_CNT_W-1:0] count
);
	import tpi_pkg::*;

	seg_t                   ent_q [OFIFO_DEPTH];
	logic [OFIFO_PTR_W-1:0] wr_ptr_q;
	logic [OFIFO_PTR_W-1:0] rd_ptr_q;
	logic [OFIFO_CNT_W-1:0] cnt_q;
	logic                   pop;

	assign rd_valid = cnt_q != '0;
	assign rd_data  = ent_q[rd_ptr_q];
	assign count    = cnt_q;
	assign pop      = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + OFIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OFIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + OFIFO_CNT_W'(wr_en) - OFIFO_CNT_W'(pop);
		end
	end

endmodule

FILE: rtl/turtle_path_interpreter.sv
// Top level of the turtle path interpreter: configuration registers, pipeline and result queue.
//
// Takes no new symbol beat while the previous one is in the decode stage: the heading
// register (or, on a pop, the heading read from the heading stack memory) is written
// from the stage-2 registers after the symbol is decoded, and the next symbol's sine
// and cosine lookup needs that heading. A result beat (segment or stack error) passes
// the decode, lookup and pose stages and the result queue before it reaches the
// output; symbols that cause neither give no beat. Up to four results are queued,
// so the input keeps flowing while the output stalls until the queue and the pipeline
// together hold four items. The pose stack memories are not cleared after reset;
// a pop only reads entries written by an earlier push. Write configuration only while idle.
module turtle_path_interpreter #(
	parameter int STACK_DEPTH  = 256,
	parameter int SYMBOL_SLOTS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  tpi_pkg::sym_t                     symbol,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_ready,
	output tpi_pkg::coord_t                   from_x,
	output tpi_pkg::coord_t                   from_y,
	output tpi_pkg::coord_t                   to_x,
	output tpi_pkg::coord_t                   to_y,
	output logic                              segment_valid,
	output logic [1:0]                        stack_error,
	input  logic                              cfg_we,
	input  logic [tpi_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [tpi_pkg::CFG_W-1:0]         cfg_data
);
	import tpi_pkg::*;

	localparam int ADDR_W = $clog2(STACK_DEPTH);

	logic [CFG_W-1:0]   draw_q;
	logic [CFG_W-1:0]   left_q;
	logic [CFG_W-1:0]   right_q;
	logic [2*SYM_W-1:0] push_pop_q;
	logic [CFG_W-1:0]   start_pos_q;
	angle_t             start_hdg_q;
	angle_t             turn_q;
	logic [STEP_W-1:0]  step_q;

	logic                   in_fire;
	logic                   busy_s1;
	angle_t                 hdg_in;
	logic                   v_s3;
	pose_ctrl_t             ctrl_s3;
	logic [ADDR_W-1:0]      addr_s3;
	mag_t                   cos_mag_s3;
	logic                   cos_neg_s3;
	mag_t                   sin_mag_s3;
	logic                   sin_neg_s3;
	logic                   done;
	logic                   res_vld;
	seg_t                   res;
	seg_t                   head;
	logic [OFIFO_CNT_W-1:0] fifo_cnt;
	logic [OFIFO_CNT_W-1:0] inflight_q;
	logic [OFIFO_CNT_W:0]   used;

	assign used     = {1'b0, inflight_q} + {1'b0, fifo_cnt};
	assign in_ready = !busy_s1 && (used < (OFIFO_CNT_W+1)'(OFIFO_DEPTH));
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_q      <= '0;
			left_q      <= '0;
			right_q     <= '0;
			push_pop_q  <= '0;
			start_pos_q <= '0;
			start_hdg_q <= '0;
			turn_q      <= '0;
			step_q      <= '0;
			inflight_q  <= '0;
		end else begin
			inflight_q <= inflight_q + OFIFO_CNT_W'(in_fire) - OFIFO_CNT_W'(done);
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_DRAW:      draw_q      <= cfg_data;
					REG_LEFT:      left_q      <= cfg_data;
					REG_RIGHT:     right_q     <= cfg_data;
					REG_PUSH_POP:  push_pop_q  <= cfg_data[2*SYM_W-1:0];
					REG_START_POS: start_pos_q <= cfg_data;
					REG_START_HDG: start_hdg_q <= cfg_data[ANG_W-1:0];
					REG_TURN:      turn_q      <= cfg_data[ANG_W-1:0];
					REG_STEP:      step_q      <= cfg_data[STEP_W-1:0];
				endcase
			end
		end
	end

	tpi_ctrl #(
		.STACK_DEPTH  (STACK_DEPTH),
		.SYMBOL_SLOTS (SYMBOL_SLOTS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.symbol        (symbol),
		.restart       (restart),
		.draw_syms     (draw_q),
		.left_syms     (left_q),
		.right_syms    (right_q),
		.push_pop      (push_pop_q),
		.start_heading (start_hdg_q),
		.turn_angle    (turn_q),
		.busy_s1       (busy_s1),
		.hdg_in        (hdg_in),
		.v_s3          (v_s3),
		.ctrl_s3       (ctrl_s3),
		.addr_s3       (addr_s3)
	);

	tpi_trig u_trig (
		.clk        (clk),
		.hdg        (hdg_in),
		.cos_mag_s3 (cos_mag_s3),
		.cos_neg_s3 (cos_neg_s3),
		.sin_mag_s3 (sin_mag_s3),
		.sin_neg_s3 (sin_neg_s3)
	);

	tpi_pose #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_pose (
		.clk            (clk),
		.arst_n         (arst_n),
		.v_s3           (v_s3),
		.ctrl_s3        (ctrl_s3),
		.addr_s3        (addr_s3),
		.cos_mag_s3     (cos_mag_s3),
		.cos_neg_s3     (cos_neg_s3),
		.sin_mag_s3     (sin_mag_s3),
		.sin_neg_s3     (sin_neg_s3),
		.step_length    (step_q),
		.start_position (start_pos_q),
		.done           (done),
		.res_vld        (res_vld),
		.res            (res)
	);

	tpi_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_vld),
		.wr_data  (res),
		.rd_en    (out_ready),
		.rd_valid (out_valid),
		.rd_data  (head),
		.count    (fifo_cnt)
	);

	assign from_x        = head.from_x;
	assign from_y        = head.from_y;
	assign to_x          = head.to_x;
	assign to_y          = head.to_y;
	assign segment_valid = head.seg_valid;
	assign stack_error   = head.err;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for turtle_path_interpreter: symbol beats in, predicted segments and stack errors checked.
module testbench;
	import tpi_pkg::*;

	localparam int SAVE_DEPTH = 256;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int REPORT_MAX = 10;
	localparam longint COORD_MAX = 64'sh7FFF_FFFF;
	localparam longint COORD_MIN = -64'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	sym_t symbol = '0;
	logic restart = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	coord_t from_x, from_y, to_x, to_y;
	logic segment_valid;
	logic [1:0] stack_error;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	turtle_path_interpreter #(
		.STACK_DEPTH(SAVE_DEPTH),
		.SYMBOL_SLOTS(8)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.symbol(symbol),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.from_x(from_x),
		.from_y(from_y),
		.to_x(to_x),
		.to_y(to_y),
		.segment_valid(segment_valid),
		.stack_error(stack_error),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	int sine_tab [33] = '{
		0, 3216, 6424, 9616, 12785, 15924, 19024, 22078,
		25080, 28020, 30893, 33692, 36410, 39040, 41576, 44011,
		46341, 48559, 50660, 52639, 54491, 56212, 57798, 59244,
		60547, 61705, 62714, 63572, 64277, 64827, 65220, 65457,
		65536
	};

	logic [63:0] draw_set = '0;
	logic [63:0] left_set = '0;
	logic [63:0] right_set = '0;
	sym_t push_sym = '0;
	sym_t pop_sym = '0;
	logic [63:0] start_pos = '0;
	angle_t start_hdg = '0;
	angle_t turn_step = '0;
	logic [STEP_W-1:0] step_len = '0;

	coord_t at_x = '0;
	coord_t at_y = '0;
	angle_t facing = '0;
	coord_t saved_x [SAVE_DEPTH];
	coord_t saved_y [SAVE_DEPTH];
	angle_t saved_hdg [SAVE_DEPTH];
	int depth = 0;

	seg_t expected_segs [$];
	int mismatches = 0;
	int cycles = 0;
	int hold_left = 0;
	bit steady = 1'b0;
	sym_t alphabet [10];

	initial begin
		forever begin
			#4 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int idle_span();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit slot_hit(input logic [63:0] set, input sym_t s);
		bit hit;
		hit = 1'b0;
		for (int k = 0; k < 8; k++) begin
			if (set[8*k +: 8] != 8'd0 && set[8*k +: 8] == s)
				hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic int sine_of(input angle_t h);
		logic [FOLD_W-1:0] fold;
		int idx, frac, base, m;
		fold = h[14] ? QUARTER_SPAN - {1'b0, h[13:0]} : {1'b0, h[13:0]};
		idx = int'(fold) >> FRAC_W;
		frac = int'(fold) & 511;
		if (idx >= 32) begin
			m = sine_tab[32];
		end else begin
			base = sine_tab[idx];
			m = base + (((sine_tab[idx + 1] - base) * frac + 256) >>> 9);
		end
		return h[15] ? -m : m;
	endfunction

	function automatic coord_t step_along(input coord_t p, input int trig);
		longint mag, delta, r;
		mag = longint'(trig < 0 ? -trig : trig);
		delta = (longint'(step_len) * mag + 32768) >>> 16;
		r = longint'(p) + (trig < 0 ? -delta : delta);
		if (r > COORD_MAX)
			r = COORD_MAX;
		if (r < COORD_MIN)
			r = COORD_MIN;
		return coord_t'(r);
	endfunction

	task automatic predict_symbol(input sym_t s, input logic rst);
		seg_t r;
		logic drew;
		logic [1:0] fault;
		r = '0;
		drew = 1'b0;
		fault = ERR_NONE;
		if (rst) begin
			at_x = start_pos[31:0];
			at_y = start_pos[63:32];
			facing = start_hdg;
			depth = 0;
		end
		if (slot_hit(draw_set, s)) begin
			r.from_x = at_x;
			r.from_y = at_y;
			r.to_x = step_along(at_x, sine_of(facing + QUARTER_TURN));
			r.to_y = step_along(at_y, sine_of(facing));
			at_x = r.to_x;
			at_y = r.to_y;
			drew = 1'b1;
		end
		if (slot_hit(left_set, s))
			facing = facing + turn_step;
		if (slot_hit(right_set, s))
			facing = facing - turn_step;
		if (push_sym != 8'd0 && s == push_sym) begin
			if (depth >= SAVE_DEPTH) begin
				fault = ERR_FULL;
			end else begin
				saved_x[depth] = at_x;
				saved_y[depth] = at_y;
				saved_hdg[depth] = facing;
				depth++;
			end
		end
		if (pop_sym != 8'd0 && s == pop_sym) begin
			if (depth == 0) begin
				fault = ERR_EMPTY;
			end else begin
				depth--;
				at_x = saved_x[depth];
				at_y = saved_y[depth];
				facing = saved_hdg[depth];
			end
		end
		if (drew || fault != ERR_NONE) begin
			r.seg_valid = drew;
			r.err = fault;
			expected_segs.push_back(r);
		end
	endtask

	task automatic send_symbol(input sym_t s, input logic rst);
		int gap;
		gap = idle_span();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		symbol <= s;
		restart <= rst;
		do @(posedge clk); while (!in_ready);
		predict_symbol(s, rst);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_segs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DRAW: draw_set = val;
			REG_LEFT: left_set = val;
			REG_RIGHT: right_set = val;
			REG_PUSH_POP: begin
				push_sym = val[7:0];
				pop_sym = val[15:8];
			end
			REG_START_POS: start_pos = val;
			REG_START_HDG: start_hdg = val[15:0];
			REG_TURN: turn_step = val[15:0];
			REG_STEP: step_len = val[30:0];
			default: ;
		endcase
	endtask

	task automatic load_config(input logic [63:0] d, input logic [63:0] l, input logic [63:0] r,
			input logic [15:0] pp, input logic [63:0] pos, input logic [15:0] hdg,
			input logic [15:0] turn, input logic [30:0] stp);
		write_reg(REG_DRAW, d);
		write_reg(REG_LEFT, l);
		write_reg(REG_RIGHT, r);
		write_reg(REG_PUSH_POP, {48'd0, pp});
		write_reg(REG_START_POS, pos);
		write_reg(REG_START_HDG, {48'd0, hdg});
		write_reg(REG_TURN, {48'd0, turn});
		write_reg(REG_STEP, {33'd0, stp});
	endtask

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = idle_span();
			end
		end
	end

	initial begin
		seg_t exp;
		bit bad;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_segs.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result beat: from(%h,%h) to(%h,%h) seg %b err %0d",
							from_x, from_y, to_x, to_y, segment_valid, stack_error);
				end else begin
					exp = expected_segs.pop_front();
					bad = (from_x !== exp.from_x) || (from_y !== exp.from_y) ||
						(to_x !== exp.to_x) || (to_y !== exp.to_y) ||
						(segment_valid !== exp.seg_valid) || (stack_error !== exp.err);
					if (bad) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display({"mismatch: exp from(%h,%h) to(%h,%h) seg %b err %0d, ",
								"got from(%h,%h) to(%h,%h) seg %b err %0d"},
								exp.from_x, exp.from_y, exp.to_x, exp.to_y, exp.seg_valid,
								exp.err, from_x, from_y, to_x, to_y, segment_valid,
								stack_error);
					end
				end
			end
		end
	end

	task automatic test_reset_defaults();
		send_symbol(8'h00, 1'b0);
		send_symbol(8'hFF, 1'b1);
		send_symbol("F", 1'b0);
		settle();
	endtask

	task automatic test_directed_path();
		load_config(64'hFF00_0000_5800_4746, 64'h0000_5800_0000_002B, 64'h0000_0000_0058_002D,
			16'h5D5B, 64'hFFFF_0000_0001_0000, 16'h2000, 16'h4000, 31'h0001_8000);
		send_symbol("F", 1'b1);
		send_symbol("G", 1'b0);
		send_symbol("+", 1'b0);
		send_symbol("[", 1'b0);
		send_symbol("F", 1'b0);
		send_symbol("]", 1'b0);
		send_symbol("]", 1'b0);
		send_symbol("-", 1'b0);
		send_symbol("-", 1'b0);
		send_symbol("X", 1'b0);
		send_symbol(8'h00, 1'b0);
		send_symbol(8'hFF, 1'b0);
		send_symbol("Q", 1'b1);
		send_symbol("F", 1'b0);
		settle();
	endtask

	task automatic test_saturation();
		load_config(64'h46, 64'h2B, 64'h0, 16'h0000, 64'h8000_0100_7FFF_FF00, 16'h2000,
			16'h8000, 31'h7FFF_FFFF);
		send_symbol("F", 1'b1);
		send_symbol("F", 1'b0);
		send_symbol("+", 1'b0);
		send_symbol("F", 1'b0);
		send_symbol("F", 1'b0);
		send_symbol("+", 1'b0);
		settle();
	endtask

	task automatic test_backpressure();
		hold_left = 400;
		steady = 1'b1;
		repeat (40) send_symbol("F", 1'b0);
		steady = 1'b0;
		settle();
	endtask

	task automatic maybe_move();
		int pick;
		if ($urandom_range(0, 3) == 0) begin
			pick = $urandom_range(0, 2);
			send_symbol(pick == 0 ? "F" : (pick == 1 ? "+" : "-"), 1'b0);
		end
	endtask

	task automatic test_stack_limits();
		load_config(64'h46, 64'h2B, 64'h2D, 16'h2928, {$urandom, $urandom}, 16'($urandom),
			16'($urandom), 31'($urandom_range(0, 32'h0003_0000)));
		send_symbol(8'h00, 1'b1);
		repeat (SAVE_DEPTH) begin
			maybe_move();
			send_symbol("(", 1'b0);
		end
		send_symbol("(", 1'b0);
		send_symbol("(", 1'b0);
		settle();
		// push and pop on one symbol
		write_reg(REG_PUSH_POP, 64'h2828);
		send_symbol("(", 1'b0);
		send_symbol("(", 1'b0);
		settle();
		write_reg(REG_PUSH_POP, 64'h2928);
		send_symbol("(", 1'b0);
		repeat (SAVE_DEPTH) begin
			send_symbol(")", 1'b0);
			maybe_move();
		end
		send_symbol(")", 1'b0);
		send_symbol(")", 1'b0);
		settle();
	endtask

	function automatic logic [63:0] rand_set();
		logic [63:0] v;
		for (int k = 0; k < 8; k++)
			v[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'h00 : alphabet[$urandom_range(0, 9)];
		return v;
	endfunction

	function automatic sym_t rand_role();
		return ($urandom_range(0, 7) == 0) ? 8'h00 : alphabet[$urandom_range(0, 9)];
	endfunction

	task automatic test_random_phase(input int kind, input int count);
		logic [63:0] d, l, r, pos;
		logic [15:0] pp, hdg, turn;
		logic [30:0] stp;
		for (int i = 0; i < 10; i++)
			alphabet[i] = 8'($urandom_range(1, 255));
		if (kind == 1)
			alphabet[0] = 8'hFF;
		d = rand_set();
		l = rand_set();
		r = rand_set();
		pp = {rand_role(), rand_role()};
		case (kind)
			0: begin
				pos = '0;
				hdg = '0;
				turn = '0;
				stp = '0;
			end
			1: begin
				pos = 64'h7FFF_FFFF_8000_0000;
				hdg = 16'hFFFF;
				turn = 16'hFFFF;
				stp = 31'h7FFF_FFFF;
			end
			default: begin
				pos = {$urandom, $urandom};
				hdg = 16'($urandom);
				turn = 16'($urandom);
				stp = 31'($urandom_range(0, 32'h0008_0000));
			end
		endcase
		load_config(d, l, r, pp, pos, hdg, turn, stp);
		send_symbol(alphabet[$urandom_range(0, 9)], 1'b1);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 85)
				send_symbol(alphabet[$urandom_range(0, 9)], $urandom_range(0, 24) == 0);
			else
				send_symbol(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
		settle();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_directed_path();
		test_saturation();
		test_backpressure();
		test_stack_limits();
		test_random_phase(0, 110);
		test_random_phase(1, 110);
		steady = 1'b1;
		test_random_phase(2, 110);
		steady = 1'b0;
		test_random_phase(3, 110);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
